// ===== rtl/bmp_rle_span_decoder_assert.svh =====
// Assertion macros shared by the span decoder RTL.
`ifndef BMP_RLE_SPAN_DECODER_ASSERT_SVH
`define BMP_RLE_SPAN_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define BRSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BRSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmprle_pkg.sv =====
// Shared constants and types for the BMP RLE span decoder.
package bmprle_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int POS_W             = 17;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [15:0] MIN_WIDTH    = 16'd8;
    localparam logic [7:0]  NIBBLE_MASK  = 8'h0f;

    // Transaction opcodes
    localparam logic [1:0] OP_LOAD_PAL  = 2'd0;
    localparam logic [1:0] OP_BYTE      = 2'd1;
    localparam logic [1:0] OP_NEW_IMAGE = 2'd2;

    // Escape codes following a zero command byte
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    typedef enum logic [2:0] {
        SG_PIXELS,
        SG_EOL,
        SG_DX,
        SG_DY,
        SG_EOB,
        SG_CLEAR
    } t_sg_kind;

    typedef struct packed {
        logic     vld;
        t_sg_kind kind;
        logic [7:0] count;
        logic [7:0] value;
    } t_sg_cmd;

endpackage

// ===== rtl/bmprle_pal_ram.sv =====
// Palette memory: one write port, two registered read ports.
module bmprle_pal_ram import bmprle_pkg::*; #(
    parameter int DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [7:0]  i_waddr,
    input  logic [23:0] i_wdata,
    input  logic        i_re,
    input  logic [7:0]  i_raddr_a,
    input  logic [7:0]  i_raddr_b,
    output logic [23:0] o_rdata_a,
    output logic [23:0] o_rdata_b
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(DEPTH);

    logic [23:0] mem [DEPTH];
    logic [23:0] r_da, r_db;
    logic        r_a_ok, r_b_ok;

    logic w_ok, ra_ok, rb_ok;
    assign w_ok  = {1'b0, i_waddr} < DEPTH_LIM;
    assign ra_ok = {1'b0, i_raddr_a} < DEPTH_LIM;
    assign rb_ok = {1'b0, i_raddr_b} < DEPTH_LIM;

    always_ff @(posedge i_clk) begin
        if (i_we && w_ok) begin
            mem[i_waddr[AW-1:0]] <= i_wdata;
        end
    end

    // Entries beyond the depth read as black.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_da   <= mem[i_raddr_a[AW-1:0]];
            r_db   <= mem[i_raddr_b[AW-1:0]];
            r_a_ok <= ra_ok;
            r_b_ok <= rb_ok;
        end
    end

    assign o_rdata_a = r_a_ok ? r_da : 24'd0;
    assign o_rdata_b = r_b_ok ? r_db : 24'd0;

endmodule

// ===== rtl/bmprle_parser.sv =====
// Byte stream parser: command/escape/absolute phases, issues span commands.
module bmprle_parser import bmprle_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_stream_byte,
    input  logic       i_rle_mode,
    output logic       o_rd_en,
    output logic [7:0] o_rd_addr_a,
    output logic [7:0] o_rd_addr_b,
    output t_sg_cmd    o_cmd
);

    typedef enum logic [2:0] {
        PH_CMD,
        PH_RUNVAL,
        PH_ESC,
        PH_DX,
        PH_DY,
        PH_ABS,
        PH_PAD,
        PH_DONE
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_pending, n_pending;
    logic       r_pad, n_pad;
    t_sg_cmd    r_cmd, n_cmd;

    logic [7:0] b;
    logic [7:0] take;
    logic [7:0] b_inc;
    logic [7:0] pend_left;

    assign b     = i_stream_byte;
    assign b_inc = b + 8'd1;
    assign take  = (r_pending >= 8'd2) ? 8'd2 : r_pending;

    assign o_rd_en     = i_accept && (i_opcode == OP_BYTE);
    assign o_rd_addr_a = i_rle_mode ? {4'h0, b[7:4]} : b;
    assign o_rd_addr_b = i_rle_mode ? (b & NIBBLE_MASK) : b;

    always_comb begin
        n_phase     = r_phase;
        n_pending   = r_pending;
        n_pad       = r_pad;
        n_cmd.vld   = 1'b0;
        n_cmd.kind  = SG_PIXELS;
        n_cmd.count = r_pending;
        n_cmd.value = b;
        pend_left   = r_pending;
        if (i_accept) begin
            unique case (i_opcode)
                OP_NEW_IMAGE: begin
                    n_phase    = PH_CMD;
                    n_pending  = 8'd0;
                    n_pad      = 1'b0;
                    n_cmd.vld  = 1'b1;
                    n_cmd.kind = SG_CLEAR;
                end
                OP_BYTE: begin
                    unique case (r_phase)
                        PH_CMD: begin
                            if (b == 8'd0) begin
                                n_phase = PH_ESC;
                            end else begin
                                n_pending = b;
                                n_phase   = PH_RUNVAL;
                            end
                        end
                        PH_RUNVAL: begin
                            n_cmd.vld   = 1'b1;
                            n_cmd.kind  = SG_PIXELS;
                            n_cmd.count = r_pending;
                            n_pending   = 8'd0;
                            n_phase     = PH_CMD;
                        end
                        PH_ESC: begin
                            unique case (b)
                                ESC_EOL: begin
                                    n_cmd.vld  = 1'b1;
                                    n_cmd.kind = SG_EOL;
                                    n_phase    = PH_CMD;
                                end
                                ESC_EOB: begin
                                    n_cmd.vld  = 1'b1;
                                    n_cmd.kind = SG_EOB;
                                    n_phase    = PH_DONE;
                                end
                                ESC_DELTA: begin
                                    n_phase = PH_DX;
                                end
                                default: begin
                                    // Pad when the run holds an odd number of data bytes.
                                    n_pending = b;
                                    n_pad     = i_rle_mode ? b_inc[1] : b[0];
                                    n_phase   = PH_ABS;
                                end
                            endcase
                        end
                        PH_DX: begin
                            n_cmd.vld  = 1'b1;
                            n_cmd.kind = SG_DX;
                            n_phase    = PH_DY;
                        end
                        PH_DY: begin
                            n_cmd.vld  = 1'b1;
                            n_cmd.kind = SG_DY;
                            n_phase    = PH_CMD;
                        end
                        PH_ABS: begin
                            n_cmd.vld  = 1'b1;
                            n_cmd.kind = SG_PIXELS;
                            if (i_rle_mode) begin
                                n_cmd.count = take;
                                pend_left   = r_pending - take;
                            end else begin
                                n_cmd.count = 8'd1;
                                pend_left   = (r_pending != 8'd0) ? r_pending - 8'd1 : 8'd0;
                            end
                            n_pending = pend_left;
                            if (pend_left == 8'd0) begin
                                n_phase = r_pad ? PH_PAD : PH_CMD;
                                n_pad   = 1'b0;
                            end
                        end
                        PH_PAD: begin
                            n_phase = PH_CMD;
                        end
                        PH_DONE: begin
                            n_phase = PH_DONE;
                        end
                        default: begin
                            n_phase = PH_CMD;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CMD;
            r_pending <= 8'd0;
            r_pad     <= 1'b0;
            r_cmd.vld <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_pad     <= n_pad;
            r_cmd     <= n_cmd;
        end
    end

    assign o_cmd = r_cmd;

endmodule

// ===== rtl/bmprle_span_gen.sv =====
// Span sequencer: position counters, row wrap, and the result register.
module bmprle_span_gen import bmprle_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sg_cmd     i_cmd,
    input  logic [23:0] i_colour_a,
    input  logic [23:0] i_colour_b,
    input  logic [15:0] i_image_width,
    input  logic [15:0] i_image_height,
    output logic        o_busy,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [15:0] o_row,
    output logic [15:0] o_start_column,
    output logic [7:0]  o_span_length,
    output logic [23:0] o_first_colour,
    output logic [23:0] o_second_colour,
    output logic        o_end_of_bitmap,
    output logic        o_last
);

    logic             r_busy, n_busy;
    logic             r_eob, n_eob;
    logic [7:0]       r_rem, n_rem;
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic             r_par, n_par;
    logic [23:0]      r_ca, n_ca, r_cb, n_cb;

    logic             r_ovld, n_ovld;
    logic [15:0]      r_orow, n_orow, r_ocol, n_ocol;
    logic [7:0]       r_olen, n_olen;
    logic [23:0]      r_oc1, n_oc1, r_oc2, n_oc2;
    logic             r_oeob, n_oeob, r_olast, n_olast;

    logic [15:0]      w_eff;
    logic [POS_W-1:0] w_lim, h_lim;
    logic             row_out, col_wrap, out_free, wrap_last;
    logic [POS_W-1:0] room, row_inc;
    logic [7:0]       len, rem_next;
    logic [POS_W:0]   col_add, row_add;

    assign w_eff    = (i_image_width < MIN_WIDTH) ? MIN_WIDTH : i_image_width;
    assign w_lim    = {1'b0, w_eff};
    assign h_lim    = {1'b0, i_image_height};
    assign row_out  = r_row >= h_lim;
    assign col_wrap = r_col >= w_lim;
    assign room     = w_lim - r_col;
    assign len      = (room < {{(POS_W-8){1'b0}}, r_rem}) ? room[7:0] : r_rem;
    assign rem_next = r_rem - len;
    assign row_inc  = (r_row == POS_MAX) ? r_row : r_row + 1'b1;
    assign wrap_last = row_inc >= h_lim;
    assign out_free = !r_ovld || i_out_ready;
    assign col_add  = {1'b0, r_col} + {{(POS_W-7){1'b0}}, i_cmd.value};
    assign row_add  = {1'b0, r_row} + {{(POS_W-7){1'b0}}, i_cmd.value};

    always_comb begin
        n_busy  = r_busy;
        n_eob   = r_eob;
        n_rem   = r_rem;
        n_col   = r_col;
        n_row   = r_row;
        n_par   = r_par;
        n_ca    = r_ca;
        n_cb    = r_cb;
        n_ovld  = r_ovld && !i_out_ready;
        n_orow  = r_orow;
        n_ocol  = r_ocol;
        n_olen  = r_olen;
        n_oc1   = r_oc1;
        n_oc2   = r_oc2;
        n_oeob  = r_oeob;
        n_olast = r_olast;
        if (i_cmd.vld) begin
            unique case (i_cmd.kind)
                SG_PIXELS: begin
                    n_busy = i_cmd.count != 8'd0;
                    n_eob  = 1'b0;
                    n_rem  = i_cmd.count;
                    n_ca   = i_colour_a;
                    n_cb   = i_colour_b;
                    n_par  = 1'b0;
                end
                SG_EOL: begin
                    n_col = '0;
                    n_row = row_inc;
                end
                SG_DX: begin
                    n_col = col_add[POS_W] ? POS_MAX : col_add[POS_W-1:0];
                end
                SG_DY: begin
                    n_row = row_add[POS_W] ? POS_MAX : row_add[POS_W-1:0];
                end
                SG_EOB: begin
                    n_busy = 1'b1;
                    n_eob  = 1'b1;
                end
                SG_CLEAR: begin
                    n_col = '0;
                    n_row = '0;
                end
                default: begin
                end
            endcase
        end else if (r_busy) begin
            if (r_eob) begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_orow  = r_row[15:0];
                    n_ocol  = r_col[15:0];
                    n_olen  = 8'd0;
                    n_oc1   = 24'd0;
                    n_oc2   = 24'd0;
                    n_oeob  = 1'b1;
                    n_olast = 1'b1;
                    n_busy  = 1'b0;
                end
            end else if (row_out) begin
                n_busy = 1'b0;
            end else if (col_wrap) begin
                n_col = '0;
                n_row = row_inc;
            end else if (out_free) begin
                n_ovld = 1'b1;
                n_orow = r_row[15:0];
                n_ocol = r_col[15:0];
                n_olen = len;
                n_oc1  = r_par ? r_cb : r_ca;
                n_oc2  = r_par ? r_ca : r_cb;
                n_oeob = 1'b0;
                n_par  = r_par ^ len[0];
                n_rem  = rem_next;
                if (rem_next == 8'd0) begin
                    n_col   = r_col + {{(POS_W-8){1'b0}}, len};
                    n_busy  = 1'b0;
                    n_olast = 1'b1;
                end else begin
                    // Span hit the right edge: wrap now, stop if the next row is off the image.
                    n_col   = '0;
                    n_row   = row_inc;
                    n_olast = wrap_last;
                    n_busy  = !wrap_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_eob  <= 1'b0;
            r_rem  <= 8'd0;
            r_col  <= '0;
            r_row  <= '0;
            r_par  <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_eob  <= n_eob;
            r_rem  <= n_rem;
            r_col  <= n_col;
            r_row  <= n_row;
            r_par  <= n_par;
            r_ovld <= n_ovld;
        end
        r_ca    <= n_ca;
        r_cb    <= n_cb;
        r_orow  <= n_orow;
        r_ocol  <= n_ocol;
        r_olen  <= n_olen;
        r_oc1   <= n_oc1;
        r_oc2   <= n_oc2;
        r_oeob  <= n_oeob;
        r_olast <= n_olast;
    end

    assign o_busy          = r_busy;
    assign o_out_valid     = r_ovld;
    assign o_row           = r_orow;
    assign o_start_column  = r_ocol;
    assign o_span_length   = r_olen;
    assign o_first_colour  = r_oc1;
    assign o_second_colour = r_oc2;
    assign o_end_of_bitmap = r_oeob;
    assign o_last          = r_olast;

endmodule

// ===== rtl/bmp_rle_span_decoder.sv =====
// Top level of the BMP RLE8/RLE4 span decoder.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | sink      | i_in_valid / o_in_ready   | opcode, palette slot/colour, stream byte
//  out     | source    | o_out_valid / i_out_ready | row, column, length, colours, eob, last
//  cfg     | sink      | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// Palette loads, ignored opcodes and parse-only bytes need no further work; position and new-image
// bytes issue a registered command, which meets the palette read data in the same cycle.
// A pixel byte also holds the input for each span and each leading row wrap, and for reaching a
// row past the last before any span; so does end of bitmap. o_in_ready stays low meanwhile.
// The result register lets the next transaction in while a span waits; a stalled output
// holds the span sequencer. Reset is synchronous; palette contents are not cleared.
module bmp_rle_span_decoder import bmprle_pkg::*; #(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_palette_slot,
    input  logic [23:0] i_palette_colour,
    input  logic [7:0]  i_stream_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_row,
    output logic [15:0] o_start_column,
    output logic [7:0]  o_span_length,
    output logic [23:0] o_first_colour,
    output logic [23:0] o_second_colour,
    output logic        o_end_of_bitmap,
    output logic        o_last
);

`include "bmp_rle_span_decoder_assert.svh"

    logic [15:0] r_image_width;
    logic [15:0] r_image_height;
    logic        r_rle_mode;

    logic        w_accept;
    logic        w_rd_en;
    logic [7:0]  w_rd_addr_a, w_rd_addr_b;
    logic [23:0] w_colour_a, w_colour_b;
    t_sg_cmd     w_cmd;
    logic        w_sg_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= MIN_WIDTH;
            r_image_height <= 16'd1;
            r_rle_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_HEIGHT: r_image_height <= i_cfg_data;
                CFG_MODE:   r_rle_mode     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Hold input while a command is in flight or spans are still being cut.
    assign o_in_ready = !w_sg_busy && !w_cmd.vld;
    assign w_accept   = i_in_valid && o_in_ready;

    bmprle_pal_ram #(
        .DEPTH(PALETTE_DEPTH)
    ) u_pal_ram (
        .i_clk    (i_clk),
        .i_we     (w_accept && (i_opcode == OP_LOAD_PAL)),
        .i_waddr  (i_palette_slot),
        .i_wdata  (i_palette_colour),
        .i_re     (w_rd_en),
        .i_raddr_a(w_rd_addr_a),
        .i_raddr_b(w_rd_addr_b),
        .o_rdata_a(w_colour_a),
        .o_rdata_b(w_colour_b)
    );

    bmprle_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_opcode     (i_opcode),
        .i_stream_byte(i_stream_byte),
        .i_rle_mode   (r_rle_mode),
        .o_rd_en      (w_rd_en),
        .o_rd_addr_a  (w_rd_addr_a),
        .o_rd_addr_b  (w_rd_addr_b),
        .o_cmd        (w_cmd)
    );

    bmprle_span_gen u_span_gen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_colour_a     (w_colour_a),
        .i_colour_b     (w_colour_b),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_busy         (w_sg_busy),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_row          (o_row),
        .o_start_column (o_start_column),
        .o_span_length  (o_span_length),
        .o_first_colour (o_first_colour),
        .o_second_colour(o_second_colour),
        .o_end_of_bitmap(o_end_of_bitmap),
        .o_last         (o_last)
    );

    `BRSD_ASSERT_NOW(a_cmd_idle, i_clk, i_rst_n, w_cmd.vld, !w_sg_busy, "command while span sequencer busy")
    `BRSD_ASSERT_NXT(a_eob_busy, i_clk, i_rst_n, w_cmd.vld && (w_cmd.kind == SG_EOB), w_sg_busy, "end of bitmap not queued")
    `BRSD_ASSERT_NOW(a_eob_shape, i_clk, i_rst_n, o_out_valid && o_end_of_bitmap, (o_span_length == 8'd0) && o_last, "bad end-of-bitmap result")
    `BRSD_ASSERT_NOW(a_span_len, i_clk, i_rst_n, o_out_valid && !o_end_of_bitmap, o_span_length != 8'd0, "empty pixel span")

endmodule
